FILE: hw/rtl/tgi_pkg.sv
// package for the trilinear grid interpolator
// types, constants and register indexes; no dependencies
`timescale 1ns / 1ps
package tgi_pkg;
  localparam int NX = 32;
  localparam int NY = 32;
  localparam int NZ = 32;
  localparam int FRAC_BITS = 16;
  localparam int ADDR_W = 15;
  localparam int DEPTH = 32768;
  localparam int DATA_W = 32;
  localparam int IDX_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int QW = 32 + FRAC_BITS + 1;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORG_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORG_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORG_Z  = 3'd5;

  typedef struct packed {
    logic               mode;
    logic [14:0]        load_index;
    logic signed [31:0] load_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] interp_value;
    logic               inside_res;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_START, ST_DIV_RUN, ST_AXIS, ST_READ, ST_WAIT,
    ST_LERP, ST_OUT
  } state_e;
endpackage

FILE: hw/rtl/tgi_ram.sv
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module tgi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

FILE: hw/rtl/tgi_div.sv
// restoring divider, one quotient bit a cycle, with remainder flag
// depends on tgi_pkg
`timescale 1ns / 1ps
module tgi_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [tgi_pkg::QW-1:0]    num_i,
  input  logic [30:0]               den_i,
  output logic                      done_o,
  output logic [tgi_pkg::QW-1:0]    quot_o,
  output logic                      rem_nz_o
);
  localparam int CW = $clog2(tgi_pkg::QW + 1);
  logic [tgi_pkg::QW-1:0] q_q, q_d;
  logic [31:0] r_q, r_d;
  logic [30:0] den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [32:0] sh;

  always_comb begin
    q_d = q_q; r_d = r_q; cnt_d = cnt_q; busy_d = busy_q;
    sh = {r_q, q_q[tgi_pkg::QW-1]};
    if (start_i) begin
      q_d = num_i; r_d = '0; cnt_d = CW'(tgi_pkg::QW); busy_d = 1'b1;
    end else if (busy_q) begin
      q_d = {q_q[tgi_pkg::QW-2:0], 1'b0};
      if (sh >= {2'b0, den_q}) begin
        r_d = 32'(sh - {2'b0, den_q});
        q_d[0] = 1'b1;
      end else begin
        r_d = sh[31:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d;
    if (start_i) den_q <= (den_i == '0) ? 31'd1 : den_i;
  end

  assign done_o = busy_q && (cnt_q == CW'(1));
  assign quot_o = q_d;
  assign rem_nz_o = (r_d != '0);
endmodule

FILE: hw/rtl/tgi_lerp.sv
// one lerp step: v0 + alpha*(v1-v0), rounded half up
// depends on tgi_pkg
`timescale 1ns / 1ps
module tgi_lerp (
  input  logic                        clk_i,
  input  logic signed [31:0]          v0_i,
  input  logic signed [31:0]          v1_i,
  input  logic [tgi_pkg::FRAC_BITS-1:0] alpha_i,
  output logic signed [31:0]          res_o
);
  logic signed [32:0] diff;
  logic signed [33+tgi_pkg::FRAC_BITS:0] prod_q;
  logic signed [31:0] v0_q;
  logic signed [34+tgi_pkg::FRAC_BITS:0] sum;
  assign diff = 33'(v1_i) - 33'(v0_i);
  always_ff @(posedge clk_i) begin
    prod_q <= diff * $signed({1'b0, alpha_i});
    v0_q <= v0_i;
  end
  assign sum = ($signed({v0_q, {tgi_pkg::FRAC_BITS{1'b0}}}) + prod_q)
             + (35 + tgi_pkg::FRAC_BITS)'(1 << (tgi_pkg::FRAC_BITS - 1));
  assign res_o = sum[tgi_pkg::FRAC_BITS +: 32];
endmodule

FILE: hw/rtl/trilinear_grid_interpolator_top.sv
// trilinear grid interpolator top level: sequencer, registers, grid ram
// depends on tgi_pkg, tgi_ram, tgi_div, tgi_lerp
`timescale 1ns / 1ps
// usage:
// input channel in_valid_i/in_stall_o carries a tgi_pkg::in_item_t; output
// channel out_valid_o/out_stall_i carries a tgi_pkg::out_item_t.
// a load transfer (mode 0) writes one sample, giving no result. an evaluate
// transfer (mode 1) gives one result. evaluate takes three serial divisions
// on the shared divider (start, 49 quotient bits, axis check), then eight
// ram reads (states read and wait), then seven lerps on the shared
// multiplier. the block takes one item at a time; in_stall_o is high while
// it works and while a result waits in the output register. the output
// register holds its result until out_stall_i is low. reset sets steps to
// 1.0 and origins to 0; grid contents stay undefined until written. the
// user must make configuration writes only while the block is idle; the
// block itself does not enforce this.
module trilinear_grid_interpolator_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tgi_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tgi_pkg::out_item_t  out_data_o,
  input  logic                cfg_we_i,
  input  logic [tgi_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i
);
  localparam int FB = tgi_pkg::FRAC_BITS;
  localparam int QW = tgi_pkg::QW;
  localparam int IDX_W_T = tgi_pkg::IDX_W;

  tgi_pkg::state_e st_q, st_d;
  logic [30:0] step_q [3];
  logic signed [31:0] org_q [3];
  logic signed [31:0] pt_q [3];
  logic [1:0] ax_q, ax_d;
  logic [IDX_W_T-1:0] li_q [3], hi_q [3];
  logic [FB-1:0] al_q [3];
  logic outside_q, outside_d;
  logic [2:0] cnt_q, cnt_d;
  logic signed [31:0] v_q [8];
  logic [3:0] lc_q, lc_d;
  logic ph_q, ph_d;
  logic ovalid_q;
  tgi_pkg::out_item_t odata_q;

  logic accept, out_xfer;
  assign accept = in_valid_i && !in_stall_o;
  assign out_xfer = ovalid_q && !out_stall_i;
  assign in_stall_o = (st_q != tgi_pkg::ST_IDLE) || ovalid_q;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        step_q[i] <= 31'(1 << FB);
        org_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tgi_pkg::REG_STEP_X: step_q[0] <= cfg_wdata_i[30:0];
        tgi_pkg::REG_STEP_Y: step_q[1] <= cfg_wdata_i[30:0];
        tgi_pkg::REG_STEP_Z: step_q[2] <= cfg_wdata_i[30:0];
        tgi_pkg::REG_ORG_X:  org_q[0] <= cfg_wdata_i;
        tgi_pkg::REG_ORG_Y:  org_q[1] <= cfg_wdata_i;
        tgi_pkg::REG_ORG_Z:  org_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // divider feed
  logic signed [32:0] dsub;
  logic [32:0] dmag;
  logic dneg_q;
  logic div_start, div_done, rem_nz;
  logic [QW-1:0] quot;
  assign dsub = 33'(pt_q[ax_q]) - 33'(org_q[ax_q]);
  assign dmag = dsub[32] ? 33'(-dsub) : dsub;
  assign div_start = (st_q == tgi_pkg::ST_DIV_START);

  tgi_div u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_i(QW'({dmag, {FB{1'b0}}})), .den_i(step_q[ax_q]),
    .done_o(div_done), .quot_o(quot), .rem_nz_o(rem_nz)
  );
  always_ff @(posedge clk_i) if (div_start) dneg_q <= dsub[32];

  // axis evaluation from quotient
  logic signed [QW:0] t;
  logic signed [QW-FB:0] lo_f, hi_f, nlim;
  logic [FB-1:0] alpha_f;
  logic [QW:0] qext;
  always_comb begin
    qext = {1'b0, quot};
    if (dneg_q) t = -$signed(qext + (QW+1)'(rem_nz));
    else t = $signed(qext);
    lo_f = t[QW:FB];
    alpha_f = t[FB-1:0];
    hi_f = lo_f + (QW-FB+1)'(alpha_f != '0);
    unique case (ax_q)
      2'd0: nlim = (QW-FB+1)'(tgi_pkg::NX);
      2'd1: nlim = (QW-FB+1)'(tgi_pkg::NY);
      default: nlim = (QW-FB+1)'(tgi_pkg::NZ);
    endcase
  end

  // ram
  logic ram_we;
  logic [tgi_pkg::ADDR_W-1:0] ram_addr, raddr;
  logic [31:0] ram_rd;
  logic [IDX_W_T-1:0] ci, cj, ck;
  assign ci = cnt_q[2] ? hi_q[0] : li_q[0];
  assign cj = cnt_q[1] ? hi_q[1] : li_q[1];
  assign ck = cnt_q[0] ? hi_q[2] : li_q[2];
  assign raddr = tgi_pkg::ADDR_W'((32'(ci) * tgi_pkg::NY + 32'(cj)) * tgi_pkg::NZ
                                  + 32'(ck));
  assign ram_we = accept && !in_data_i.mode;
  assign ram_addr = ram_we ? in_data_i.load_index : raddr;
  tgi_ram #(.WIDTH(32), .DEPTH(tgi_pkg::DEPTH)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr),
    .wdata_i(in_data_i.load_value), .rdata_o(ram_rd)
  );

  // lerp schedule: lc 0..3 z-lerps, 4..5 y-lerps, 6 x-lerp
  logic signed [31:0] l0, l1, lres;
  logic [FB-1:0] la;
  always_comb begin
    l0 = v_q[0]; l1 = v_q[1]; la = al_q[2];
    unique case (lc_q)
      4'd0: begin l0 = v_q[0]; l1 = v_q[1]; la = al_q[2]; end
      4'd1: begin l0 = v_q[2]; l1 = v_q[3]; la = al_q[2]; end
      4'd2: begin l0 = v_q[4]; l1 = v_q[5]; la = al_q[2]; end
      4'd3: begin l0 = v_q[6]; l1 = v_q[7]; la = al_q[2]; end
      4'd4: begin l0 = v_q[0]; l1 = v_q[1]; la = al_q[1]; end
      4'd5: begin l0 = v_q[2]; l1 = v_q[3]; la = al_q[1]; end
      default: begin l0 = v_q[4]; l1 = v_q[5]; la = al_q[0]; end
    endcase
  end
  tgi_lerp u_lerp (.clk_i, .v0_i(l0), .v1_i(l1), .alpha_i(la), .res_o(lres));

  // sequencer
  always_comb begin
    st_d = st_q; ax_d = ax_q; outside_d = outside_q; cnt_d = cnt_q;
    lc_d = lc_q; ph_d = ph_q;
    unique case (st_q)
      tgi_pkg::ST_IDLE: if (accept && in_data_i.mode) begin
        st_d = tgi_pkg::ST_DIV_START; ax_d = '0; outside_d = 1'b0;
      end
      tgi_pkg::ST_DIV_START: st_d = tgi_pkg::ST_DIV_RUN;
      tgi_pkg::ST_DIV_RUN: if (div_done) st_d = tgi_pkg::ST_AXIS;
      tgi_pkg::ST_AXIS: begin
        if (hi_f < 0 || lo_f >= nlim) outside_d = 1'b1;
        if (ax_q == 2'd2) begin
          st_d = (outside_d) ? tgi_pkg::ST_OUT : tgi_pkg::ST_READ;
          cnt_d = '0;
        end else begin
          ax_d = ax_q + 2'd1; st_d = tgi_pkg::ST_DIV_START;
        end
      end
      tgi_pkg::ST_READ: st_d = tgi_pkg::ST_WAIT;
      tgi_pkg::ST_WAIT: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          st_d = tgi_pkg::ST_LERP; lc_d = '0; ph_d = 1'b0;
        end else st_d = tgi_pkg::ST_READ;
      end
      tgi_pkg::ST_LERP: begin
        ph_d = !ph_q;
        if (ph_q) begin
          lc_d = lc_q + 4'd1;
          if (lc_q == 4'd6) st_d = tgi_pkg::ST_OUT;
        end
      end
      tgi_pkg::ST_OUT: st_d = tgi_pkg::ST_IDLE;
      default: st_d = tgi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= tgi_pkg::ST_IDLE; ax_q <= '0; outside_q <= 1'b0;
      cnt_q <= '0; lc_q <= '0; ph_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d; ax_q <= ax_d; outside_q <= outside_d;
      cnt_q <= cnt_d; lc_q <= lc_d; ph_q <= ph_d;
      if (st_q == tgi_pkg::ST_OUT) ovalid_q <= 1'b1;
      else if (out_xfer) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pt_q[0] <= in_data_i.point_x;
      pt_q[1] <= in_data_i.point_y;
      pt_q[2] <= in_data_i.point_z;
    end
    if (st_q == tgi_pkg::ST_AXIS) begin
      logic [FB-1:0] a;
      a = alpha_f;
      if (lo_f < 0) begin li_q[ax_q] <= '0; a = '0; end
      else li_q[ax_q] <= IDX_W_T'(lo_f);
      if (hi_f >= nlim) begin hi_q[ax_q] <= IDX_W_T'(nlim - 1); a = '0; end
      else hi_q[ax_q] <= IDX_W_T'(hi_f);
      al_q[ax_q] <= a;
    end
    if (st_q == tgi_pkg::ST_WAIT) v_q[cnt_q] <= ram_rd;
    if (st_q == tgi_pkg::ST_LERP && ph_q) begin
      unique case (lc_q)
        4'd0: v_q[0] <= lres;
        4'd1: v_q[1] <= lres;
        4'd2: v_q[2] <= lres;
        4'd3: v_q[3] <= lres;
        4'd4: v_q[4] <= lres;
        4'd5: v_q[5] <= lres;
        default: v_q[6] <= lres;
      endcase
    end
    if (st_q == tgi_pkg::ST_OUT) begin
      odata_q.inside_res <= !outside_q;
      odata_q.interp_value <= outside_q ? 32'sd0 : v_q[6];
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o = odata_q;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != tgi_pkg::ST_IDLE) |-> in_stall_o) else $error("accept while busy");
  a_out_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(st_q) == tgi_pkg::ST_OUT) else $error("bad result");
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !odata_q.inside_res) |-> odata_q.interp_value == 0)
    else $error("outside nonzero");
`endif
endmodule
